FILE: src/cpagc_pkg.sv
package cpagc_pkg;

	localparam int unsigned PCM_W   = 16;
	localparam int unsigned GAIN_W  = 23;
	localparam int unsigned COEF_W  = 17;
	localparam int unsigned PEAK_W  = 16;
	localparam int unsigned CFG_W   = 23;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned QUO_W   = 31;
	localparam int unsigned PROD_W  = GAIN_W + COEF_W;

	localparam logic [15:0]       TARGET_RST  = 16'd29491;
	localparam logic [GAIN_W-1:0] CEIL_RST    = 23'd4194304;
	localparam logic [GAIN_W-1:0] FLOOR_RST   = 23'd16384;
	localparam logic [COEF_W-1:0] ATTACK_RST  = 17'd32768;
	localparam logic [COEF_W-1:0] RELEASE_RST = 17'd3277;
	localparam logic [15:0]       QUIET_RST   = 16'd98;
	localparam logic [GAIN_W-1:0] UNITY_GAIN  = 23'd65536;

	typedef enum logic [CIDX_W-1:0] {
		CFG_TARGET  = 3'd0,
		CFG_CEIL    = 3'd1,
		CFG_FLOOR   = 3'd2,
		CFG_ATTACK  = 3'd3,
		CFG_RELEASE = 3'd4,
		CFG_QUIET   = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_FILL,
		S_DIV,
		S_DES,
		S_SMUL,
		S_STEP,
		S_CLAMP,
		S_RD,
		S_RMUL,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic signed [PCM_W-1:0] pcm_in;
		logic                    chunk_end;
	} in_item_t;

	typedef struct packed {
		logic signed [PCM_W-1:0] pcm_out;
		logic                    run_end;
		logic [PEAK_W-1:0]       input_peak;
		logic [GAIN_W-1:0]       gain_used;
		logic [PEAK_W-1:0]       output_peak;
	} out_item_t;

endpackage

FILE: src/cpagc_chan_if.sv
interface cpagc_chan_if #(parameter type item_t = logic);

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

FILE: src/chunk_peak_agc.sv
// Chunk peak AGC. Samples are taken one per cycle into a CHUNK_DEPTH-entry buffer while the
// input peak is tracked; the chunk closes on chunk_end or when the buffer is full, and no
// sample is taken until every scaled result of that chunk has been handed to the output
// register. Closing runs a restoring divide (target / peak) in S_DIV and then the gain update
// in S_DES, S_SMUL and S_STEP; when the peak is at or below quiet_threshold both are skipped and
// only the final clamp in S_CLAMP remains. Replay then steps each sample through S_RD, S_RMUL and
// S_EMIT, paced by the single buffer read port and the one shared 23x17 multiplier that serves
// both the gain step and the sample scaling. Gain is unsigned Q7.16 and resets to unity;
// configuration registers must be written while the block is idle.
module chunk_peak_agc #(
	parameter int unsigned CHUNK_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cpagc_pkg::CIDX_W-1:0]    cfg_idx,
	input  logic [cpagc_pkg::CFG_W-1:0]     cfg_data,
	cpagc_chan_if.sink                      samples,
	cpagc_chan_if.source                    results
);

	localparam int unsigned AW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
	localparam int unsigned FW = $clog2(CHUNK_DEPTH + 1);
	localparam int unsigned GW = cpagc_pkg::GAIN_W;
	localparam int unsigned CW = cpagc_pkg::COEF_W;
	localparam int unsigned PW = cpagc_pkg::PROD_W;
	localparam int unsigned QW = cpagc_pkg::QUO_W;

	cpagc_pkg::state_t state_q, state_nxt;

	logic [15:0]   target_q;
	logic [GW-1:0] ceil_q;
	logic [GW-1:0] floor_q;
	logic [CW-1:0] attack_q;
	logic [CW-1:0] release_q;
	logic [15:0]   quiet_q;

	logic [15:0]   mem [CHUNK_DEPTH];
	logic [15:0]   rd_q;

	logic [FW-1:0] fill_q;
	logic [FW-1:0] n_q;
	logic [FW-1:0] k_q;
	logic [15:0]   peak_q;
	logic [GW-1:0] gain_q;

	logic [15:0]   div_rem_q;
	logic [QW-1:0] div_quo_q;
	logic [4:0]    div_cnt_q;

	logic          dir_neg_q;
	logic [GW-1:0] dmag_q;
	logic [CW-1:0] coeff_q;
	logic [PW-1:0] prod_q;
	logic signed [GW+2:0] adj_q;

	logic [15:0]   out_peak_q;
	logic          out_valid_q;
	cpagc_pkg::out_item_t out_q;

	logic [16:0]   in_mag;
	logic [15:0]   peak_nxt;
	logic [FW-1:0] fill_nxt;
	logic          take;
	logic          closing;

	logic [16:0]   trial;
	logic          trial_ge;

	logic [31:0]   want_ext;
	logic [GW-1:0] desired;

	logic [23:0]   step_amt;
	logic signed [GW+2:0] lo_s;
	logic signed [GW+2:0] hi_s;
	logic [GW-1:0] clamped;

	logic [16:0]   rd_mag;
	logic [GW-1:0] mul_a;
	logic [CW-1:0] mul_b;
	logic          use_step_mul;

	logic [23:0]   scaled;
	logic [16:0]   omag;
	logic [15:0]   res_pcm;
	logic [15:0]   peak_with_last;
	logic          slot_free;
	logic          emit;
	logic          last_k;

	// input side
	assign in_mag   = samples.data.pcm_in[15] ? (17'h10000 - {1'b0, samples.data.pcm_in})
	                                          : {1'b0, samples.data.pcm_in};
	assign peak_nxt = (in_mag[15:0] > peak_q) ? in_mag[15:0] : peak_q;
	assign fill_nxt = fill_q + 1'b1;
	assign take     = samples.valid && samples.ready;
	assign closing  = samples.data.chunk_end || (fill_nxt == FW'(CHUNK_DEPTH));

	// divider step
	assign trial    = {div_rem_q, div_quo_q[QW-1]};
	assign trial_ge = trial >= {1'b0, peak_q};

	// desired gain clamp
	assign want_ext = {1'b0, div_quo_q};
	always_comb begin
		if (want_ext < {9'd0, floor_q}) begin
			desired = floor_q;
		end else if (want_ext > {9'd0, ceil_q}) begin
			desired = ceil_q;
		end else begin
			desired = want_ext[GW-1:0];
		end
	end

	// final gain clamp
	assign step_amt = prod_q[PW-1:16];
	assign lo_s     = $signed({3'd0, floor_q});
	assign hi_s     = $signed({3'd0, ceil_q});
	always_comb begin
		if (adj_q < lo_s) begin
			clamped = floor_q;
		end else if (adj_q > hi_s) begin
			clamped = ceil_q;
		end else begin
			clamped = adj_q[GW-1:0];
		end
	end

	// shared multiplier operands
	assign rd_mag = rd_q[15] ? (17'h10000 - {1'b0, rd_q}) : {1'b0, rd_q};
	assign mul_a  = use_step_mul ? dmag_q : gain_q;
	assign mul_b  = use_step_mul ? coeff_q : rd_mag;

	// saturation
	assign scaled = prod_q[PW-1:16];
	always_comb begin
		if (rd_q[15]) begin
			omag    = (scaled > 24'd32768) ? 17'd32768 : scaled[16:0];
			res_pcm = 16'(17'h10000 - omag);
		end else begin
			omag    = (scaled > 24'd32767) ? 17'd32767 : scaled[16:0];
			res_pcm = omag[15:0];
		end
	end
	assign peak_with_last = (omag[15:0] > out_peak_q) ? omag[15:0] : out_peak_q;
	assign slot_free      = !out_valid_q || results.ready;
	assign last_k         = (k_q + 1'b1) == n_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			cpagc_pkg::S_FILL: begin
				if (take && closing) begin
					state_nxt = (peak_nxt > quiet_q) ? cpagc_pkg::S_DIV : cpagc_pkg::S_CLAMP;
				end
			end
			cpagc_pkg::S_DIV: begin
				if (div_cnt_q == 5'(QW - 1)) begin
					state_nxt = cpagc_pkg::S_DES;
				end
			end
			cpagc_pkg::S_DES:   state_nxt = cpagc_pkg::S_SMUL;
			cpagc_pkg::S_SMUL:  state_nxt = cpagc_pkg::S_STEP;
			cpagc_pkg::S_STEP:  state_nxt = cpagc_pkg::S_CLAMP;
			cpagc_pkg::S_CLAMP: state_nxt = cpagc_pkg::S_RD;
			cpagc_pkg::S_RD:    state_nxt = cpagc_pkg::S_RMUL;
			cpagc_pkg::S_RMUL:  state_nxt = cpagc_pkg::S_EMIT;
			cpagc_pkg::S_EMIT: begin
				if (slot_free) begin
					state_nxt = last_k ? cpagc_pkg::S_FILL : cpagc_pkg::S_RD;
				end
			end
			default: state_nxt = cpagc_pkg::S_FILL;
		endcase
	end

	// state outputs
	always_comb begin
		samples.ready = 1'b0;
		use_step_mul  = 1'b0;
		emit          = 1'b0;
		case (state_q)
			cpagc_pkg::S_FILL: samples.ready = 1'b1;
			cpagc_pkg::S_SMUL: use_step_mul  = 1'b1;
			cpagc_pkg::S_EMIT: emit          = slot_free;
			default: begin
				samples.ready = 1'b0;
			end
		endcase
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpagc_pkg::S_FILL;
		end else begin
			state_q <= state_nxt;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= cpagc_pkg::TARGET_RST;
			ceil_q    <= cpagc_pkg::CEIL_RST;
			floor_q   <= cpagc_pkg::FLOOR_RST;
			attack_q  <= cpagc_pkg::ATTACK_RST;
			release_q <= cpagc_pkg::RELEASE_RST;
			quiet_q   <= cpagc_pkg::QUIET_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				cpagc_pkg::CFG_TARGET:  target_q  <= cfg_data[15:0];
				cpagc_pkg::CFG_CEIL:    ceil_q    <= cfg_data[GW-1:0];
				cpagc_pkg::CFG_FLOOR:   floor_q   <= cfg_data[GW-1:0];
				cpagc_pkg::CFG_ATTACK:  attack_q  <= cfg_data[CW-1:0];
				cpagc_pkg::CFG_RELEASE: release_q <= cfg_data[CW-1:0];
				cpagc_pkg::CFG_QUIET:   quiet_q   <= cfg_data[15:0];
				default: begin
					quiet_q <= quiet_q;
				end
			endcase
		end
	end

	// chunk buffer
	always_ff @(posedge clk) begin
		if (take) begin
			mem[fill_q[AW-1:0]] <= samples.data.pcm_in;
		end
		rd_q <= mem[k_q[AW-1:0]];
	end

	// chunk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			n_q        <= '0;
			k_q        <= '0;
			peak_q     <= '0;
			gain_q     <= cpagc_pkg::UNITY_GAIN;
			out_peak_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				fill_q <= fill_nxt;
				peak_q <= peak_nxt;
				n_q    <= fill_nxt;
			end
			if (state_q == cpagc_pkg::S_CLAMP) begin
				gain_q     <= clamped;
				k_q        <= '0;
				out_peak_q <= '0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_peak_q  <= peak_with_last;
				if (last_k) begin
					fill_q <= '0;
					peak_q <= '0;
					k_q    <= '0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// gain datapath
	always_ff @(posedge clk) begin
		if (take && closing) begin
			div_rem_q <= '0;
			div_quo_q <= {target_q, 15'd0};
			div_cnt_q <= '0;
			adj_q     <= $signed({3'd0, gain_q});
		end
		if (state_q == cpagc_pkg::S_DIV) begin
			div_rem_q <= trial_ge ? 16'(trial - {1'b0, peak_q}) : trial[15:0];
			div_quo_q <= {div_quo_q[QW-2:0], trial_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (state_q == cpagc_pkg::S_DES) begin
			dir_neg_q <= desired < gain_q;
			dmag_q    <= (desired < gain_q) ? (gain_q - desired) : (desired - gain_q);
			coeff_q   <= (desired < gain_q) ? attack_q : release_q;
		end
		if (state_q == cpagc_pkg::S_SMUL || state_q == cpagc_pkg::S_RMUL) begin
			prod_q <= {{CW{1'b0}}, mul_a} * {{GW{1'b0}}, mul_b};
		end
		if (state_q == cpagc_pkg::S_STEP) begin
			adj_q <= dir_neg_q ? ($signed({3'd0, gain_q}) - $signed({2'd0, step_amt}))
			                   : ($signed({3'd0, gain_q}) + $signed({2'd0, step_amt}));
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.pcm_out     <= res_pcm;
			out_q.run_end     <= last_k;
			out_q.input_peak  <= last_k ? peak_q : 16'd0;
			out_q.gain_used   <= gain_q;
			out_q.output_peak <= last_k ? peak_with_last : 16'd0;
		end
	end

endmodule

FILE: tb/tb_chunk_peak_agc.sv
`timescale 1ns / 1ps

module tb_chunk_peak_agc;

	localparam int unsigned DEPTH  = 64;
	localparam int unsigned PCM_W  = cpagc_pkg::PCM_W;
	localparam int unsigned GAIN_W = cpagc_pkg::GAIN_W;
	localparam int unsigned COEF_W = cpagc_pkg::COEF_W;
	localparam int unsigned PEAK_W = cpagc_pkg::PEAK_W;
	localparam int unsigned CFG_W  = cpagc_pkg::CFG_W;
	localparam int unsigned CIDX_W = cpagc_pkg::CIDX_W;

	typedef enum int {
		SRC_FULL,
		SRC_QUIET,
		SRC_EDGE,
		SRC_SCALED
	} src_kind_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CIDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	cpagc_chan_if #(.item_t(cpagc_pkg::in_item_t)) samples_ch ();
	cpagc_chan_if #(.item_t(cpagc_pkg::out_item_t)) results_ch ();

	chunk_peak_agc #(.CHUNK_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.samples(samples_ch),
		.results(results_ch)
	);

	// predictor copy of the configuration and state
	logic [15:0] cfg_target = cpagc_pkg::TARGET_RST;
	logic [GAIN_W-1:0] cfg_ceil = cpagc_pkg::CEIL_RST;
	logic [GAIN_W-1:0] cfg_floor = cpagc_pkg::FLOOR_RST;
	logic [COEF_W-1:0] cfg_attack = cpagc_pkg::ATTACK_RST;
	logic [COEF_W-1:0] cfg_release = cpagc_pkg::RELEASE_RST;
	logic [15:0] cfg_quiet = cpagc_pkg::QUIET_RST;

	logic signed [PCM_W-1:0] chunk_buf[$];
	logic [PEAK_W-1:0] chunk_peak = '0;
	logic [GAIN_W-1:0] gain_now = cpagc_pkg::UNITY_GAIN;

	cpagc_pkg::out_item_t scaled_q[$];

	int n_errors = 0;
	int n_samples = 0;
	int n_results = 0;
	int n_chunks = 0;
	int n_configs = 0;
	int n_holds = 0;

	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int rx_gap = 0;
	int hold_req = 0;
	int hold_left = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint clamp_gain(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void agc_take_sample(input cpagc_pkg::in_item_t it);
		logic [PEAK_W-1:0] mag;
		longint lo, hi, g, want, desired, coeff, diff, dmag, delta_g;
		longint u, smag, prod, opeak;
		logic signed [PCM_W-1:0] s;
		cpagc_pkg::out_item_t r;
		chunk_buf.push_back(it.pcm_in);
		mag = it.pcm_in[PCM_W-1] ? (~it.pcm_in + 16'd1) : it.pcm_in;
		if (mag > chunk_peak)
			chunk_peak = mag;
		if (!it.chunk_end && chunk_buf.size() < DEPTH)
			return;

		lo = longint'(cfg_floor);
		hi = longint'(cfg_ceil);
		g = longint'(gain_now);
		if (chunk_peak > cfg_quiet) begin
			want = (longint'(cfg_target) * 32768) / longint'(chunk_peak);
			desired = clamp_gain(want, lo, hi);
			coeff = (desired < g) ? longint'(cfg_attack) : longint'(cfg_release);
			diff = desired - g;
			dmag = (diff < 0) ? -diff : diff;
			delta_g = (dmag * coeff) >>> 16;
			g = (diff < 0) ? g - delta_g : g + delta_g;
		end
		g = clamp_gain(g, lo, hi);
		gain_now = g[GAIN_W-1:0];

		opeak = 0;
		for (int k = 0; k < chunk_buf.size(); k++) begin
			s = chunk_buf[k];
			u = longint'($unsigned(s));
			smag = s[PCM_W-1] ? 65536 - u : u;
			prod = (smag * longint'(gain_now)) >>> 16;
			if (s[PCM_W-1]) begin
				if (prod > 32768)
					prod = 32768;
				r.pcm_out = PCM_W'(65536 - prod);
			end else begin
				if (prod > 32767)
					prod = 32767;
				r.pcm_out = PCM_W'(prod);
			end
			if (prod > opeak)
				opeak = prod;
			r.run_end = 1'b0;
			r.input_peak = '0;
			r.gain_used = gain_now;
			r.output_peak = '0;
			if (k == chunk_buf.size() - 1) begin
				r.run_end = 1'b1;
				r.input_peak = chunk_peak;
				r.output_peak = PEAK_W'(opeak);
			end
			scaled_q.push_back(r);
		end
		chunk_buf.delete();
		chunk_peak = '0;
		n_chunks++;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s at result %0d: got %0d, expected %0d",
			what, n_results, got, want);
		n_errors++;
	endtask

	// input and output monitors
	always @(posedge clk) begin
		cpagc_pkg::out_item_t want;
		if (arst_n) begin
			if (samples_ch.valid && samples_ch.ready) begin
				agc_take_sample(samples_ch.data);
				n_samples++;
			end
			if (results_ch.valid && results_ch.ready) begin
				if (scaled_q.size() == 0) begin
					report_mismatch("item with no prediction",
						longint'($signed(results_ch.data.pcm_out)), longint'(0));
				end else begin
					want = scaled_q.pop_front();
					if (results_ch.data.pcm_out !== want.pcm_out)
						report_mismatch("pcm_out", longint'($signed(results_ch.data.pcm_out)),
							longint'($signed(want.pcm_out)));
					if (results_ch.data.run_end !== want.run_end)
						report_mismatch("run_end", longint'(results_ch.data.run_end),
							longint'(want.run_end));
					if (results_ch.data.input_peak !== want.input_peak)
						report_mismatch("input_peak", longint'(results_ch.data.input_peak),
							longint'(want.input_peak));
					if (results_ch.data.gain_used !== want.gain_used)
						report_mismatch("gain_used", longint'(results_ch.data.gain_used),
							longint'(want.gain_used));
					if (results_ch.data.output_peak !== want.output_peak)
						report_mismatch("output_peak", longint'(results_ch.data.output_peak),
							longint'(want.output_peak));
				end
				n_results++;
				rx_gap = rx_calm ? 0 : $urandom_range(0, 11);
			end
		end
	end

	// output ready, with per-item gaps and long hold-offs
	initial results_ch.ready = 1'b0;

	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			results_ch.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			results_ch.ready <= 1'b0;
		end else begin
			results_ch.ready <= 1'b1;
		end
	end

	task automatic send_sample(input logic signed [PCM_W-1:0] pcm, input logic eoc);
		cpagc_pkg::in_item_t it;
		int gap;
		it.pcm_in = pcm;
		it.chunk_end = eoc;
		gap = tx_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.data <= it;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [PCM_W-1:0] pick_sample(input src_kind_t kind);
		logic signed [PCM_W-1:0] v;
		v = PCM_W'($urandom);
		case (kind)
			SRC_QUIET: v = PCM_W'(int'($urandom_range(0, 240)) - 120);
			SRC_EDGE: begin
				case ($urandom_range(0, 4))
					0: v = -16'sd32768;
					1: v = 16'sd32767;
					2: v = 16'sd0;
					3: v = -16'sd1;
					default: v = 16'sd1;
				endcase
			end
			SRC_SCALED: v = v >>> $urandom_range(1, 12);
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_chunk(input int len, input src_kind_t kind, input bit mark_end);
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(kind), mark_end && (i == len - 1));
	endtask

	// wait for every predicted item, then let the block return to idle
	task automatic settle_block();
		samples_ch.valid <= 1'b0;
		while (scaled_q.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input cpagc_pkg::cfg_reg_t r, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_data <= v;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [15:0] tgt, input logic [GAIN_W-1:0] ceil_v,
		input logic [GAIN_W-1:0] floor_v, input logic [COEF_W-1:0] atk,
		input logic [COEF_W-1:0] rel, input logic [15:0] quiet);
		write_reg(cpagc_pkg::CFG_TARGET, CFG_W'(tgt));
		write_reg(cpagc_pkg::CFG_CEIL, ceil_v);
		write_reg(cpagc_pkg::CFG_FLOOR, floor_v);
		write_reg(cpagc_pkg::CFG_ATTACK, CFG_W'(atk));
		write_reg(cpagc_pkg::CFG_RELEASE, CFG_W'(rel));
		write_reg(cpagc_pkg::CFG_QUIET, CFG_W'(quiet));
		cfg_we <= 1'b0;
		cfg_target = tgt;
		cfg_ceil = ceil_v;
		cfg_floor = floor_v;
		cfg_attack = atk;
		cfg_release = rel;
		cfg_quiet = quiet;
		n_configs++;
	endtask

	task automatic test_defaults();
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd32768, 1'b1);
		send_sample(16'sd98, 1'b0);
		send_sample(-16'sd98, 1'b1);
		send_sample(16'sd99, 1'b1);
		send_sample(-16'sd1, 1'b1);
		send_sample(16'sd1, 1'b1);
		settle_block();
	endtask

	task automatic test_full_store();
		send_chunk(DEPTH, SRC_FULL, 1'b0);
		send_sample(-16'sd20000, 1'b1);
		settle_block();
	endtask

	task automatic test_saturation();
		set_config(16'hFFFF, 23'd4194304, 23'd4194304, 17'd65536, 17'd65536, 16'd0);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd512, 1'b0);
		send_sample(-16'sd512, 1'b0);
		send_sample(16'sd511, 1'b0);
		send_sample(-16'sd511, 1'b1);
		settle_block();
		set_config(16'hFFFF, 23'd4194304, 23'd0, 17'd65536, 17'd65536, 16'd0);
		send_sample(16'sd1, 1'b1);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd300, 1'b1);
		settle_block();
	endtask

	task automatic test_inverted_bounds();
		set_config(16'd29491, 23'd0, 23'd4194304, 17'd0, 17'd0, 16'd32768);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b1);
		settle_block();
		set_config(16'd29491, 23'd0, 23'd4194304, 17'd65536, 17'd65536, 16'd0);
		send_sample(16'sd1000, 1'b1);
		settle_block();
	endtask

	task automatic test_zero_gain();
		set_config(16'd0, 23'd0, 23'd0, 17'd0, 17'd65536, 16'd0);
		send_sample(16'sd12345, 1'b0);
		send_sample(-16'sd32768, 1'b1);
		settle_block();
		set_config(16'd0, 23'd4194304, 23'd0, 17'd65536, 17'd0, 16'd0);
		send_sample(-16'sd5, 1'b1);
		settle_block();
	endtask

	task automatic test_attack_release();
		set_config(cpagc_pkg::TARGET_RST, cpagc_pkg::CEIL_RST, cpagc_pkg::FLOOR_RST,
			cpagc_pkg::ATTACK_RST, cpagc_pkg::RELEASE_RST, cpagc_pkg::QUIET_RST);
		send_sample(16'sd30000, 1'b0);
		send_sample(-16'sd31000, 1'b1);
		send_sample(16'sd500, 1'b1);
		send_sample(16'sd800, 1'b0);
		send_sample(-16'sd700, 1'b1);
		send_sample(-16'sd32768, 1'b1);
		settle_block();
	endtask

	task automatic test_backpressure();
		tx_calm = 1'b1;
		@(posedge clk);
		hold_req = 300;
		@(negedge clk);
		repeat (3) send_chunk(5, SRC_FULL, 1'b1);
		tx_calm = 1'b0;
		settle_block();
		n_holds++;
	endtask

	task automatic test_random();
		int round_samples;
		int len;
		logic [GAIN_W-1:0] ceil_v;
		logic [GAIN_W-1:0] floor_v;
		for (int round = 0; round < 3; round++) begin
			ceil_v = $urandom_range(0, 1) ? GAIN_W'($urandom_range(65536, 262144))
				: GAIN_W'($urandom_range(0, 4194304));
			floor_v = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom_range(0, 4194304))
				: GAIN_W'($urandom_range(0, ceil_v));
			set_config(16'($urandom_range(0, 65535)), ceil_v, floor_v,
				COEF_W'($urandom_range(0, 65536)), COEF_W'($urandom_range(0, 65536)),
				16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32768)
					: $urandom_range(0, 300)));
			round_samples = 0;
			while (round_samples < 6) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				rx_calm = ($urandom_range(0, 3) == 0);
				len = $urandom_range(1, 6);
				send_chunk(len, src_kind_t'($urandom_range(0, 3)), 1'b1);
				round_samples += len;
				if ($urandom_range(0, 3) == 0)
					settle_block();
			end
			tx_calm = 1'b0;
			rx_calm = 1'b0;
			settle_block();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		samples_ch.valid = 1'b0;
		samples_ch.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_defaults();
		test_full_store();
		test_saturation();
		test_inverted_bounds();
		test_zero_gain();
		test_attack_release();
		test_backpressure();
		test_random();

		samples_ch.valid <= 1'b0;
		while (scaled_q.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);

		$display("covered %0d samples in %0d chunks, %0d scaled items checked",
			n_samples, n_chunks, n_results);
		$display("%0d register settings, %0d long output hold-offs", n_configs, n_holds);
		if (n_errors == 0)
			$display("PASS chunk_peak_agc");
		else
			$display("FAIL chunk_peak_agc");
		$finish;
	end

	initial begin
		#2ms;
		$display("timeout with %0d items outstanding", scaled_q.size());
		$display("FAIL chunk_peak_agc");
		$finish;
	end

endmodule

FILE: chunk_peak_agc.f
src/cpagc_pkg.sv
src/cpagc_chan_if.sv
src/chunk_peak_agc.sv
tb/tb_chunk_peak_agc.sv
